// ===== hdl/hpwf_pkg.sv =====
package hpwf_pkg;

	localparam int unsigned PIXEL_ID_BITS = 12;
	localparam int unsigned CFG_BITS      = 16;
	localparam int unsigned CFG_IDX_BITS  = 4;

	localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_EVENTS = 4'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_HOT_COUNT     = 4'd1;

	localparam logic [CFG_BITS-1:0] WINDOW_EVENTS_RESET = 16'd100;
	localparam logic [CFG_BITS-1:0] HOT_COUNT_RESET     = 16'd50;

	localparam logic ACTION_HIT = 1'b0;
	localparam logic ACTION_EOE = 1'b1;

	typedef struct packed {
		logic                     action;
		logic [PIXEL_ID_BITS-1:0] pixel_id;
	} in_word_t;

	typedef struct packed {
		logic [PIXEL_ID_BITS-1:0] hot_pixel;
		logic                     found;
		logic                     last;
		logic                     truncated;
	} out_word_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HIT_WR,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic accept_hit;
		logic accept_eoe;
		logic hit_wr;
		logic ptr_rst;
		logic ptr_inc;
		logic clr_wr;
		logic scan_rd;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic window_close;
		logic ptr_end;
	} dp_status_t;

endpackage

// ===== hdl/hpwf_ram.sv =====
module hpwf_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/hpwf_ctrl.sv =====
module hpwf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                action,
	input  hpwf_pkg::dp_status_t status,
	output hpwf_pkg::ctrl_cmd_t  cmd,
	output logic                busy
);

	import hpwf_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (status.ptr_end) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					if (action == ACTION_HIT) begin
						state_d = S_HIT_WR;
					end else if (status.window_close) begin
						state_d = S_SCAN;
					end
				end
			end
			S_HIT_WR: state_d = S_IDLE;
			S_SCAN: begin
				if (status.ptr_end) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN:  state_d = S_FINISH;
			S_FINISH: state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_wr  = 1'b1;
				cmd.ptr_inc = 1'b1;
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					if (action == ACTION_HIT) begin
						cmd.accept_hit = 1'b1;
					end else begin
						cmd.accept_eoe = 1'b1;
						cmd.ptr_rst    = status.window_close;
					end
				end
			end
			S_HIT_WR: cmd.hit_wr = 1'b1;
			S_SCAN: begin
				cmd.scan_rd = 1'b1;
				cmd.ptr_inc = 1'b1;
			end
			S_DRAIN:  cmd = '0;
			S_FINISH: cmd.finish = 1'b1;
			default:  busy = 1'b1;
		endcase
	end

endmodule

// ===== hdl/hpwf_dpath.sv =====
module hpwf_dpath #(
	parameter int unsigned PIXEL_BITS = 12,
	parameter int unsigned MAX_HOT    = 64,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  hpwf_pkg::in_word_t                   item,
	input  hpwf_pkg::ctrl_cmd_t                  cmd,
	output hpwf_pkg::dp_status_t                 status,
	input  logic                                 cfg_we,
	input  logic [hpwf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [hpwf_pkg::CFG_BITS-1:0]        cfg_data,
	output logic                                 result_valid,
	output hpwf_pkg::out_word_t                  result
);

	import hpwf_pkg::*;

	localparam int unsigned AW    = PIXEL_BITS;
	localparam int unsigned DEPTH = 1 << PIXEL_BITS;
	localparam int unsigned CW    = (COUNT_BITS > CFG_BITS) ? COUNT_BITS : CFG_BITS;
	localparam int unsigned NW    = $clog2(MAX_HOT + 1);

	logic [CFG_BITS-1:0]   window_events_q;
	logic [CFG_BITS-1:0]   hot_count_q;
	logic [CFG_BITS-1:0]   event_count_q;
	logic [CFG_BITS-1:0]   event_next;

	logic [31:0]           pid_ext;
	logic [AW-1:0]         item_addr;
	logic [AW-1:0]         hit_addr_q;
	logic [AW-1:0]         ptr_q;
	logic [AW-1:0]         addr_s1;
	logic                  valid_s1;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [COUNT_BITS-1:0] ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [COUNT_BITS-1:0] ram_rdata;
	logic [COUNT_BITS-1:0] count_inc;

	logic                  hot_s1;
	logic [NW-1:0]         found_q;
	logic                  room;
	logic                  trunc_q;
	logic [AW-1:0]         pend_addr_q;
	logic                  res_valid_q;
	out_word_t             res_q;

	assign pid_ext   = 32'(item.pixel_id);
	assign item_addr = pid_ext[AW-1:0];

	assign event_next          = event_count_q + CFG_BITS'(1);
	assign status.window_close = (item.action == ACTION_EOE) && (event_next == window_events_q);
	assign status.ptr_end      = (ptr_q == {AW{1'b1}});

	// Configuration registers and the event count of the open window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_events_q <= WINDOW_EVENTS_RESET;
			hot_count_q     <= HOT_COUNT_RESET;
			event_count_q   <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_WINDOW_EVENTS) begin
				window_events_q <= cfg_data;
			end
			if (cfg_we && cfg_index == CFG_HOT_COUNT) begin
				hot_count_q <= cfg_data;
			end
			if (cmd.finish) begin
				event_count_q <= '0;
			end else if (cmd.accept_eoe) begin
				event_count_q <= event_next;
			end
		end
	end

	// The read port follows the scan pointer while scanning, else the incoming pixel.
	assign ram_raddr = cmd.scan_rd ? ptr_q : item_addr;
	assign count_inc = (ram_rdata == {COUNT_BITS{1'b1}}) ? ram_rdata
	                                                    : ram_rdata + COUNT_BITS'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hit_addr_q;
		ram_wdata = count_inc;
		priority if (cmd.hit_wr) begin
			ram_we = 1'b1;
		end else if (cmd.clr_wr) begin
			ram_we    = 1'b1;
			ram_waddr = ptr_q;
			ram_wdata = '0;
		end else if (valid_s1) begin
			// Each counter is cleared right after the scan has read it.
			ram_we    = 1'b1;
			ram_waddr = addr_s1;
			ram_wdata = '0;
		end
	end

	hpwf_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(DEPTH)
	) u_counters (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign hot_s1 = CW'(ram_rdata) >= CW'(hot_count_q);
	assign room   = found_q < NW'(MAX_HOT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q       <= '0;
			valid_s1    <= 1'b0;
			found_q     <= '0;
			trunc_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			valid_s1    <= cmd.scan_rd;
			res_valid_q <= 1'b0;
			if (cmd.ptr_rst) begin
				ptr_q <= '0;
			end else if (cmd.ptr_inc) begin
				ptr_q <= ptr_q + AW'(1);
			end
			if (cmd.ptr_rst) begin
				found_q <= '0;
				trunc_q <= 1'b0;
			end else if (valid_s1 && hot_s1) begin
				if (room) begin
					found_q <= found_q + NW'(1);
					// A held hot pixel goes out once a later one shows it is not the last.
					if (found_q != '0) begin
						res_valid_q <= 1'b1;
					end
				end else begin
					trunc_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				res_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_hit) begin
			hit_addr_q <= item_addr;
		end
		addr_s1 <= ptr_q;
		if (valid_s1 && hot_s1 && room) begin
			pend_addr_q <= addr_s1;
			res_q       <= '{hot_pixel: PIXEL_ID_BITS'(pend_addr_q), found: 1'b1,
			                 last: 1'b0, truncated: 1'b0};
		end
		if (cmd.finish) begin
			if (found_q == '0) begin
				res_q <= '{hot_pixel: '0, found: 1'b0, last: 1'b1, truncated: 1'b0};
			end else begin
				res_q <= '{hot_pixel: PIXEL_ID_BITS'(pend_addr_q), found: 1'b1,
				           last: 1'b1, truncated: trunc_q};
			end
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

// ===== hdl/hot_pixel_window_finder.sv =====
// Hit word: busy in the cycle after acceptance while the count is written back, so the next word waits.
// End-of-event word that leaves the window open: the next word is taken in the next cycle.
// Window close: busy while the counter memory is walked at one address a cycle; hot pixels
// stream out during the walk, the last-marked word follows it.
// Results are one-cycle strobes; the receiver cannot stall them.
// After reset the block is busy while it zeroes the counter memory.
module hot_pixel_window_finder #(
	parameter int unsigned PIXEL_BITS = 12,
	parameter int unsigned MAX_HOT    = 64,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  hpwf_pkg::in_word_t                item,
	output logic                              result_valid,
	output hpwf_pkg::out_word_t               result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hpwf_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [hpwf_pkg::CFG_BITS-1:0]     cfg_data
);

	import hpwf_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	assign cfg_ready = 1'b1;

	hpwf_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.action(item.action),
		.status(status),
		.cmd   (cmd),
		.busy  (busy)
	);

	hpwf_dpath #(
		.PIXEL_BITS(PIXEL_BITS),
		.MAX_HOT   (MAX_HOT),
		.COUNT_BITS(COUNT_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

// ===== hdl/hpwf_checker.sv =====
module hpwf_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              start,
	input logic                              busy,
	input hpwf_pkg::in_word_t                item,
	input logic                              result_valid,
	input hpwf_pkg::out_word_t               result
);

	import hpwf_pkg::*;

	// An empty window gives a single word, so a word without a pixel always closes the run.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.found |-> result.last)
		else $error("result without a pixel is not marked last");

	a_trunc_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.truncated |-> result.last && result.found)
		else $error("truncated flag outside the last word of a full run");

	// Words before the last one are produced during the scan, while the block is busy.
	a_mid_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.last |-> busy)
		else $error("intermediate result outside a scan");

	a_last_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("block still busy when the run closes");

	a_hit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && item.action == ACTION_HIT |=> busy && !result_valid)
		else $error("hit update did not hold the block busy");

endmodule

bind hot_pixel_window_finder hpwf_checker u_hpwf_checker (.*);

// ===== verif/hot_pixel_window_finder_tb.sv =====
`timescale 1ns / 1ps

module hot_pixel_window_finder_tb;
	import hpwf_pkg::*;

	localparam int NUM_PIX        = 1 << PIXEL_ID_BITS;
	localparam int MAX_HOT_WORDS  = 64;
	localparam int HIT_BITS       = 16;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TAIL_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int POOL_SIZE      = 8;

	logic                    clk          = 1'b0;
	logic                    arst_n       = 1'b0;
	logic                    start        = 1'b0;
	logic                    busy;
	in_word_t                item         = '0;
	logic                    result_valid;
	out_word_t               result;
	logic                    cfg_valid    = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index    = CFG_WINDOW_EVENTS;
	logic [CFG_BITS-1:0]     cfg_data     = '0;

	// Own copy of the block state and its configuration.
	logic [HIT_BITS-1:0] pix_hits [0:NUM_PIX-1];
	logic [15:0]         events_seen   = '0;
	logic [CFG_BITS-1:0] window_len    = WINDOW_EVENTS_RESET;
	logic [CFG_BITS-1:0] hot_threshold = HOT_COUNT_RESET;

	out_word_t pending_reports [$];
	int        mismatches   = 0;
	int        quiet_cycles = 0;
	bit        no_idle      = 1'b0;
	out_word_t want;

	hot_pixel_window_finder u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.item         (item),
		.result_valid (result_valid),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	initial begin
		foreach (pix_hits[i]) pix_hits[i] = '0;
	end

	function automatic void close_window();
		logic [PIXEL_ID_BITS-1:0] hot_list [$];
		bit                       dropped;
		out_word_t                w;
		int                       p;
		dropped = 1'b0;
		for (p = 0; p < NUM_PIX; p++) begin
			if (pix_hits[p] >= hot_threshold) begin
				if (hot_list.size() < MAX_HOT_WORDS)
					hot_list.push_back(p[PIXEL_ID_BITS-1:0]);
				else
					dropped = 1'b1;
			end
		end
		if (hot_list.size() == 0) begin
			w = '0;
			w.last = 1'b1;
			pending_reports.push_back(w);
		end else begin
			foreach (hot_list[i]) begin
				w.hot_pixel = hot_list[i];
				w.found     = 1'b1;
				w.last      = (i == hot_list.size() - 1);
				w.truncated = w.last && dropped;
				pending_reports.push_back(w);
			end
		end
		foreach (pix_hits[i]) pix_hits[i] = '0;
		events_seen = '0;
	endfunction

	function automatic void count_word(input in_word_t w);
		if (w.action == ACTION_HIT) begin
			if (pix_hits[w.pixel_id] != {HIT_BITS{1'b1}})
				pix_hits[w.pixel_id] = pix_hits[w.pixel_id] + 1'b1;
		end else begin
			events_seen = events_seen + 1'b1;
			if (events_seen == window_len)
				close_window();
		end
	endfunction

	function automatic in_word_t hit_word(input int unsigned pix);
		in_word_t w;
		w.action   = ACTION_HIT;
		w.pixel_id = pix[PIXEL_ID_BITS-1:0];
		return w;
	endfunction

	// The pixel field of an end-of-event word carries noise.
	function automatic in_word_t eoe_word();
		in_word_t    w;
		int unsigned pix;
		pix        = $urandom_range(NUM_PIX - 1);
		w.action   = ACTION_EOE;
		w.pixel_id = pix[PIXEL_ID_BITS-1:0];
		return w;
	endfunction

	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Called on a clock edge; returns on the edge at which the word is taken.
	task automatic send_word(input in_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item  <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		count_word(w);
	endtask

	// Waits until every predicted word has come out. A hit word may still be in
	// flight after the last result, so the task then waits out SETTLE_CYCLES.
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
	                         input logic [CFG_BITS-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_WINDOW_EVENTS)
			window_len = value;
		else if (idx == CFG_HOT_COUNT)
			hot_threshold = value;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [15:0] expected,
	                           input logic [15:0] actual);
		if (actual !== expected) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			if (pending_reports.size() == 0) begin
				$error("result word with none expected: hot_pixel %0d found %0b",
				       result.hot_pixel, result.found);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				check_field("hot_pixel", 16'(want.hot_pixel), 16'(result.hot_pixel));
				check_field("found", 16'(want.found), 16'(result.found));
				check_field("last", 16'(want.last), 16'(result.last));
				check_field("truncated", 16'(want.truncated), 16'(result.truncated));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// Reset values: window of 100 events, hot at 50 hits.
	task automatic test_reset_values();
		no_idle = 1'b1;
		repeat (50) send_word(hit_word(NUM_PIX - 1));
		repeat (100) send_word(eoe_word());
		no_idle = 1'b0;
		settle();
	endtask

	task automatic test_threshold_edges();
		write_reg(CFG_WINDOW_EVENTS, 16'd1);
		write_reg(CFG_HOT_COUNT, 16'd2);
		// Nothing reaches the threshold, so a single empty word closes the window.
		send_word(hit_word(0));
		send_word(hit_word(NUM_PIX - 1));
		send_word(eoe_word());
		send_word(hit_word(2048));
		send_word(hit_word(1));
		send_word(hit_word(2048));
		send_word(eoe_word());
		settle();
		write_reg(CFG_HOT_COUNT, 16'd1);
		send_word(hit_word(0));
		send_word(hit_word(2048));
		send_word(hit_word(NUM_PIX - 1));
		send_word(eoe_word());
		settle();
	endtask

	task automatic test_truncation();
		write_reg(CFG_WINDOW_EVENTS, 16'd2);
		for (int i = 0; i <= MAX_HOT_WORDS; i++)
			send_word(hit_word(i * 63));
		send_word(eoe_word());
		send_word(eoe_word());
		settle();
	endtask

	task automatic test_threshold_zero();
		write_reg(CFG_WINDOW_EVENTS, 16'd1);
		write_reg(CFG_HOT_COUNT, 16'd0);
		send_word(eoe_word());
		settle();
	endtask

	// A long window stays open across a couple of events, so nothing comes out.
	task automatic test_long_window();
		write_reg(CFG_WINDOW_EVENTS, 16'hFFFF);
		write_reg(CFG_HOT_COUNT, 16'd1);
		send_word(hit_word(1234));
		send_word(eoe_word());
		send_word(eoe_word());
		settle();
	endtask

	task automatic test_random_windows(input int num_words);
		int unsigned pool [POOL_SIZE];
		int          sent;
		in_word_t    w;
		sent = 0;
		while (sent < num_words) begin
			settle();
			write_reg(CFG_WINDOW_EVENTS, CFG_BITS'(events_seen + $urandom_range(1, 5)));
			write_reg(CFG_HOT_COUNT, CFG_BITS'($urandom_range(1, 4)));
			no_idle = ($urandom_range(3) == 0);
			foreach (pool[i]) pool[i] = $urandom_range(NUM_PIX - 1);
			repeat (40) begin
				if ($urandom_range(3) == 0)
					w = eoe_word();
				else if ($urandom_range(4) == 0)
					w = hit_word($urandom_range(NUM_PIX - 1));
				else
					w = hit_word(pool[$urandom_range(POOL_SIZE - 1)]);
				send_word(w);
				sent++;
			end
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_threshold_edges();
		test_truncation();
		test_threshold_zero();
		test_long_window();
		test_random_windows(40);
		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
